FILE: rtl/core/btlpm_pkg.sv
package btlpm_pkg;

    localparam int ADDR_BITS = 32;
    localparam int LEN_W     = $clog2(ADDR_BITS + 1);
    localparam int DATA_W    = 64;
    localparam int REQ_W     = 3;
    localparam int STAT_W    = 2;
    localparam int LIMIT_W   = 9;

    localparam int ROUTE_ENTRIES_DEF = 256;
    localparam int NODE_ENTRIES_DEF  = 8192;

    localparam logic [LIMIT_W-1:0] ROUTE_LIMIT_RST = 9'd256;

    // register indexes on the config port
    localparam logic REG_HCE   = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SET    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MATCH  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DELETE,
        OP_SET,
        OP_GET,
        OP_MATCH,
        OP_BAD
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [ADDR_BITS-1:0] addr;
        logic [LEN_W-1:0]     len;
        logic [DATA_W-1:0]    data;
        logic                 clr;
    } t_item;

endpackage

FILE: rtl/core/btlpm_front.sv
module btlpm_front
    import btlpm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ADDR_BITS-1:0] i_prefix_bits,
    input  logic [LEN_W-1:0]     i_prefix_len,
    input  logic [DATA_W-1:0]    i_data_in,
    input  logic                 i_clear_hits,
    output logic                 o_item_valid,
    output t_item                o_item,
    input  logic                 i_pop
);

    t_item       r_q [0:1];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    t_item       cls;
    logic        push;

    always_comb begin
        unique case (i_req_type)
            REQ_INSERT: cls.op = OP_INSERT;
            REQ_DELETE: cls.op = OP_DELETE;
            REQ_SET:    cls.op = OP_SET;
            REQ_GET:    cls.op = OP_GET;
            REQ_MATCH:  cls.op = OP_MATCH;
            default:    cls.op = OP_BAD;
        endcase
        cls.addr = i_prefix_bits;
        cls.len  = (i_prefix_len > LEN_W'(ADDR_BITS)) ? LEN_W'(ADDR_BITS) : i_prefix_len;
        cls.data = i_data_in;
        cls.clr  = i_clear_hits;
    end

    assign o_in_stall   = (r_cnt == 2'd2);
    assign push         = i_in_valid && !o_in_stall;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !(i_pop && o_item_valid)) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!push && i_pop && o_item_valid) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_item_valid) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

FILE: rtl/core/btlpm_back.sv
module btlpm_back
    import btlpm_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
    parameter int NODE_ENTRIES  = NODE_ENTRIES_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_item_valid,
    input  t_item                i_item,
    output logic                 o_pop,
    input  logic                 i_hce,
    input  logic [LIMIT_W-1:0]   i_limit,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [DATA_W-1:0]    o_data_out,
    output logic [LEN_W-1:0]     o_match_len,
    output logic [DATA_W-1:0]    o_hits
);

    localparam int NW  = $clog2(NODE_ENTRIES + 1);
    localparam int RW  = $clog2(ROUTE_ENTRIES + 1);
    localparam int CW  = (RW > LIMIT_W) ? RW : LIMIT_W;
    localparam int AIW = $clog2(ADDR_BITS);

    typedef enum logic [18:0] {
        S_IDLE     = 19'h00001,
        S_WALK_RD  = 19'h00002,
        S_WALK_CHK = 19'h00004,
        S_RT_USE   = 19'h00008,
        S_INS_ROOT = 19'h00010,
        S_GROW_NEW = 19'h00020,
        S_GROW_LNK = 19'h00040,
        S_INS_FIN  = 19'h00080,
        S_DEL_MV   = 19'h00100,
        S_PR_RD    = 19'h00200,
        S_PR_CHK   = 19'h00400,
        S_PR_PAR   = 19'h00800,
        S_PR_TAIL  = 19'h01000,
        S_PR_TCP   = 19'h02000,
        S_PR_CR    = 19'h04000,
        S_PR_CL    = 19'h08000,
        S_PR_GPW   = 19'h10000,
        S_PR_NEXT  = 19'h20000,
        S_DONE     = 19'h40000
    } t_state;

    // node pool
    logic [NW-1:0] m_left   [0:NODE_ENTRIES];
    logic [NW-1:0] m_right  [0:NODE_ENTRIES];
    logic [NW-1:0] m_parent [0:NODE_ENTRIES];
    logic [RW-1:0] m_nroute [0:NODE_ENTRIES];
    // route pool
    logic [DATA_W-1:0] m_rdata [0:ROUTE_ENTRIES];
    logic [DATA_W-1:0] m_rhits [0:ROUTE_ENTRIES];
    logic [NW-1:0]     m_rown  [0:ROUTE_ENTRIES];

    logic [NW-1:0] nm_ra, nm_wa, nm_wd_l, nm_wd_r, nm_wd_p;
    logic [RW-1:0] nm_wd_rt;
    logic          nm_we_l, nm_we_r, nm_we_p, nm_we_rt;
    logic [NW-1:0] nm_rd_l, nm_rd_r, nm_rd_p;
    logic [RW-1:0] nm_rd_rt;

    logic [RW-1:0]     rm_ra, rm_wa;
    logic [DATA_W-1:0] rm_wd_d, rm_wd_h;
    logic [NW-1:0]     rm_wd_o;
    logic              rm_we_d, rm_we_h, rm_we_o;
    logic [DATA_W-1:0] rm_rd_d, rm_rd_h;
    logic [NW-1:0]     rm_rd_o;

    t_state               r_state, n_state;
    t_op                  r_op, n_op;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [LEN_W-1:0]     r_len, n_len;
    logic [DATA_W-1:0]    r_data, n_data;
    logic                 r_clr, n_clr;
    logic [NW-1:0]        r_root, n_root;
    logic [NW-1:0]        r_nused, n_nused;
    logic [RW-1:0]        r_rused, n_rused;
    logic [NW-1:0]        r_p, n_p;
    logic [LEN_W-1:0]     r_i, n_i;
    logic [RW-1:0]        r_rt, n_rt;
    logic [NW-1:0]        r_node, n_node;
    logic [NW-1:0]        r_par, n_par;
    logic [NW-1:0]        r_tail, n_tail;
    logic [NW-1:0]        r_tl, n_tl, r_tr, n_tr, r_tp, n_tp;
    logic [RW-1:0]        r_best_r, n_best_r;
    logic [LEN_W-1:0]     r_best_d, n_best_d;
    logic [STAT_W-1:0]    r_res_st, n_res_st;
    logic [DATA_W-1:0]    r_res_d, n_res_d;
    logic [LEN_W-1:0]     r_res_len, n_res_len;
    logic [DATA_W-1:0]    r_res_h, n_res_h;
    logic                 r_ovalid, n_ovalid;
    logic [STAT_W-1:0]    r_o_st;
    logic [DATA_W-1:0]    r_o_d, r_o_h;
    logic [LEN_W-1:0]     r_o_len;
    logic                 load_out;

    logic          cur_bit;
    logic [NW-1:0] child;
    logic          lim_full;
    logic [CW-1:0] lim_eff;
    logic [NW-1:0] next_par;

    assign lim_eff  = (CW'(i_limit) > CW'(ROUTE_ENTRIES)) ? CW'(ROUTE_ENTRIES) : CW'(i_limit);
    assign lim_full = CW'(r_rused) >= lim_eff;
    assign cur_bit  = r_addr[AIW'(ADDR_BITS - 1) - r_i[AIW-1:0]];
    assign child    = cur_bit ? nm_rd_r : nm_rd_l;
    assign next_par = (r_node != r_tail && r_par == r_tail) ? r_node : r_par;

    assign o_pop       = (r_state == S_IDLE) && i_item_valid;
    assign load_out    = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);
    assign o_out_valid = r_ovalid;
    assign o_status    = r_o_st;
    assign o_data_out  = r_o_d;
    assign o_match_len = r_o_len;
    assign o_hits      = r_o_h;

    always_comb begin
        n_state = r_state;   n_op = r_op;       n_addr = r_addr;   n_len = r_len;
        n_data = r_data;     n_clr = r_clr;     n_root = r_root;   n_nused = r_nused;
        n_rused = r_rused;   n_p = r_p;         n_i = r_i;         n_rt = r_rt;
        n_node = r_node;     n_par = r_par;     n_tail = r_tail;
        n_tl = r_tl;         n_tr = r_tr;       n_tp = r_tp;
        n_best_r = r_best_r; n_best_d = r_best_d;
        n_res_st = r_res_st; n_res_d = r_res_d; n_res_len = r_res_len; n_res_h = r_res_h;
        n_ovalid = r_ovalid;

        nm_ra = r_p;  nm_wa = r_p;
        nm_wd_l = '0; nm_wd_r = '0; nm_wd_p = '0; nm_wd_rt = '0;
        nm_we_l = 1'b0; nm_we_r = 1'b0; nm_we_p = 1'b0; nm_we_rt = 1'b0;
        rm_ra = r_rt; rm_wa = r_rt;
        rm_wd_d = r_data; rm_wd_h = '0; rm_wd_o = '0;
        rm_we_d = 1'b0; rm_we_h = 1'b0; rm_we_o = 1'b0;

        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_op = i_item.op;     n_addr = i_item.addr; n_len = i_item.len;
                    n_data = i_item.data; n_clr = i_item.clr;
                    n_res_st = STAT_MISS; n_res_d = '0; n_res_len = '0; n_res_h = '0;
                    n_p = r_root; n_i = '0;
                    n_best_r = '0; n_best_d = '0;
                    n_state = S_DONE;
                    if (i_item.op == OP_INSERT) begin
                        if (lim_full) begin
                            n_res_st = STAT_FULL;
                        end else if (r_root == '0) begin
                            if (32'(r_nused) + 32'd1 + 32'(i_item.len) > 32'(NODE_ENTRIES)) begin
                                n_res_st = STAT_FULL;
                            end else begin
                                n_rt    = r_rused + RW'(1);
                                n_rused = r_rused + RW'(1);
                                n_state = S_INS_ROOT;
                            end
                        end else begin
                            n_state = S_WALK_RD;
                        end
                    end else if (i_item.op != OP_BAD && r_root != '0 && r_nused != '0) begin
                        n_state = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD: begin
                nm_ra   = r_p;
                n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (r_op == OP_MATCH) begin
                    if (nm_rd_rt != '0) begin
                        n_best_r = nm_rd_rt;
                        n_best_d = r_i;
                    end
                    if (r_i >= LEN_W'(ADDR_BITS) || child == '0) begin
                        if (n_best_r != '0) begin
                            rm_ra   = n_best_r;
                            n_rt    = n_best_r;
                            n_state = S_RT_USE;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else begin
                        n_p     = child;
                        n_i     = r_i + LEN_W'(1);
                        n_state = S_WALK_RD;
                    end
                end else if (r_i == r_len) begin
                    // exact node found
                    n_state = S_DONE;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (nm_rd_rt == '0) begin
                                nm_wa = r_p; nm_we_rt = 1'b1; nm_wd_rt = r_rused + RW'(1);
                                rm_wa = r_rused + RW'(1);
                                rm_we_d = 1'b1; rm_we_h = 1'b1; rm_we_o = 1'b1;
                                rm_wd_h = '0;   rm_wd_o = r_p;
                                n_rused  = r_rused + RW'(1);
                                n_res_st = STAT_OK;
                            end
                        end
                        OP_DELETE: begin
                            if (nm_rd_rt != '0) begin
                                nm_wa = r_p; nm_we_rt = 1'b1; nm_wd_rt = '0;
                                n_node = r_p;
                                n_rt   = nm_rd_rt;
                                if (nm_rd_rt != r_rused) begin
                                    rm_ra   = r_rused;
                                    n_state = S_DEL_MV;
                                end else begin
                                    n_rused = r_rused - RW'(1);
                                    n_state = S_PR_RD;
                                end
                            end
                        end
                        OP_SET, OP_GET: begin
                            if (nm_rd_rt != '0) begin
                                rm_ra   = nm_rd_rt;
                                n_rt    = nm_rd_rt;
                                n_state = S_RT_USE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end else if (child == '0) begin
                    n_state = S_DONE;
                    if (r_op == OP_INSERT) begin
                        if (32'(r_nused) + 32'(r_len) - 32'(r_i) > 32'(NODE_ENTRIES)) begin
                            n_res_st = STAT_FULL;
                        end else begin
                            n_rt    = r_rused + RW'(1);
                            n_rused = r_rused + RW'(1);
                            n_state = S_GROW_NEW;
                        end
                    end
                end else begin
                    n_p     = child;
                    n_i     = r_i + LEN_W'(1);
                    n_state = S_WALK_RD;
                end
            end
            S_RT_USE: begin
                n_res_st = STAT_OK;
                n_state  = S_DONE;
                if (r_op == OP_SET) begin
                    rm_we_d = 1'b1;
                end else if (r_op == OP_GET) begin
                    n_res_d = rm_rd_d;
                    if (i_hce) begin
                        n_res_h = rm_rd_h;
                        if (r_clr) begin
                            rm_we_h = 1'b1;
                        end
                    end
                end else begin
                    n_res_d   = rm_rd_d;
                    n_res_len = r_best_d;
                    if (i_hce) begin
                        rm_we_h = 1'b1;
                        rm_wd_h = rm_rd_h + DATA_W'(1);
                    end
                end
            end
            S_INS_ROOT: begin
                nm_wa = r_nused + NW'(1);
                nm_we_l = 1'b1; nm_we_r = 1'b1; nm_we_p = 1'b1; nm_we_rt = 1'b1;
                nm_wd_rt = (r_len == '0) ? r_rt : '0;
                n_root  = r_nused + NW'(1);
                n_p     = r_nused + NW'(1);
                n_nused = r_nused + NW'(1);
                n_i     = '0;
                n_state = (r_len == '0) ? S_INS_FIN : S_GROW_NEW;
            end
            S_GROW_NEW: begin
                nm_wa = r_nused + NW'(1);
                nm_we_l = 1'b1; nm_we_r = 1'b1; nm_we_p = 1'b1; nm_we_rt = 1'b1;
                nm_wd_p  = r_p;
                nm_wd_rt = ((r_i + LEN_W'(1)) == r_len) ? r_rt : '0;
                n_node  = r_nused + NW'(1);
                n_nused = r_nused + NW'(1);
                n_state = S_GROW_LNK;
            end
            S_GROW_LNK: begin
                nm_wa = r_p;
                nm_wd_l = r_node; nm_wd_r = r_node;
                nm_we_l = !cur_bit; nm_we_r = cur_bit;
                n_p = r_node;
                n_i = r_i + LEN_W'(1);
                n_state = ((r_i + LEN_W'(1)) == r_len) ? S_INS_FIN : S_GROW_NEW;
            end
            S_INS_FIN: begin
                rm_wa = r_rt;
                rm_we_d = 1'b1; rm_we_h = 1'b1; rm_we_o = 1'b1;
                rm_wd_o  = r_p;
                n_res_st = STAT_OK;
                n_state  = S_DONE;
            end
            S_DEL_MV: begin
                // tail route moves into the freed slot
                rm_wa = r_rt;
                rm_we_d = 1'b1; rm_we_h = 1'b1; rm_we_o = 1'b1;
                rm_wd_d = rm_rd_d; rm_wd_h = rm_rd_h; rm_wd_o = rm_rd_o;
                nm_wa = rm_rd_o; nm_we_rt = 1'b1; nm_wd_rt = r_rt;
                n_rused = r_rused - RW'(1);
                n_state = S_PR_RD;
            end
            S_PR_RD: begin
                nm_ra   = r_node;
                n_state = S_PR_CHK;
            end
            S_PR_CHK: begin
                n_par = nm_rd_p;
                if (nm_rd_rt != '0 || nm_rd_l != '0 || nm_rd_r != '0) begin
                    n_res_st = STAT_OK;
                    n_state  = S_DONE;
                end else if (nm_rd_p != '0) begin
                    nm_ra   = nm_rd_p;
                    n_state = S_PR_PAR;
                end else begin
                    n_root  = '0;
                    n_state = S_PR_TAIL;
                end
            end
            S_PR_PAR: begin
                nm_wa = r_par;
                if (nm_rd_l == r_node) begin
                    nm_we_l = 1'b1;
                end else begin
                    nm_we_r = 1'b1;
                end
                n_state = S_PR_TAIL;
            end
            S_PR_TAIL: begin
                n_tail = r_nused;
                if (r_node != r_nused) begin
                    nm_ra   = r_nused;
                    n_state = S_PR_TCP;
                end else begin
                    n_state = S_PR_NEXT;
                end
            end
            S_PR_TCP: begin
                nm_wa = r_node;
                nm_we_l = 1'b1; nm_we_r = 1'b1; nm_we_p = 1'b1; nm_we_rt = 1'b1;
                nm_wd_l = nm_rd_l; nm_wd_r = nm_rd_r; nm_wd_p = nm_rd_p; nm_wd_rt = nm_rd_rt;
                if (nm_rd_rt != '0) begin
                    rm_wa = nm_rd_rt; rm_we_o = 1'b1; rm_wd_o = r_node;
                end
                n_tl = nm_rd_l; n_tr = nm_rd_r; n_tp = nm_rd_p;
                n_state = S_PR_CR;
            end
            S_PR_CR: begin
                nm_wa = r_tr; nm_wd_p = r_node; nm_we_p = (r_tr != '0);
                n_state = S_PR_CL;
            end
            S_PR_CL: begin
                nm_wa = r_tl; nm_wd_p = r_node; nm_we_p = (r_tl != '0);
                nm_ra = r_tp;
                if (r_tp == '0) begin
                    n_root  = r_node;
                    n_state = S_PR_NEXT;
                end else begin
                    n_state = S_PR_GPW;
                end
            end
            S_PR_GPW: begin
                nm_wa = r_tp; nm_wd_l = r_node; nm_wd_r = r_node;
                if (nm_rd_l == r_tail) begin
                    nm_we_l = 1'b1;
                end else begin
                    nm_we_r = 1'b1;
                end
                n_state = S_PR_NEXT;
            end
            S_PR_NEXT: begin
                n_nused = r_nused - NW'(1);
                n_node  = next_par;
                if (next_par == '0) begin
                    n_res_st = STAT_OK;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_PR_RD;
                end
            end
            S_DONE: begin
                if (load_out) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_root   <= '0;
            r_nused  <= '0;
            r_rused  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_root   <= n_root;
            r_nused  <= n_nused;
            r_rused  <= n_rused;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op;     r_addr <= n_addr; r_len <= n_len;   r_data <= n_data;
        r_clr <= n_clr;   r_p <= n_p;       r_i <= n_i;       r_rt <= n_rt;
        r_node <= n_node; r_par <= n_par;   r_tail <= n_tail;
        r_tl <= n_tl;     r_tr <= n_tr;     r_tp <= n_tp;
        r_best_r <= n_best_r; r_best_d <= n_best_d;
        r_res_st <= n_res_st; r_res_d <= n_res_d;
        r_res_len <= n_res_len; r_res_h <= n_res_h;
        if (load_out) begin
            r_o_st  <= r_res_st;
            r_o_d   <= r_res_d;
            r_o_len <= r_res_len;
            r_o_h   <= r_res_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (nm_we_l)  m_left[nm_wa]   <= nm_wd_l;
        if (nm_we_r)  m_right[nm_wa]  <= nm_wd_r;
        if (nm_we_p)  m_parent[nm_wa] <= nm_wd_p;
        if (nm_we_rt) m_nroute[nm_wa] <= nm_wd_rt;
        nm_rd_l  <= m_left[nm_ra];
        nm_rd_r  <= m_right[nm_ra];
        nm_rd_p  <= m_parent[nm_ra];
        nm_rd_rt <= m_nroute[nm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (rm_we_d) m_rdata[rm_wa] <= rm_wd_d;
        if (rm_we_h) m_rhits[rm_wa] <= rm_wd_h;
        if (rm_we_o) m_rown[rm_wa]  <= rm_wd_o;
        rm_rd_d <= m_rdata[rm_ra];
        rm_rd_h <= m_rhits[rm_ra];
        rm_rd_o <= m_rown[rm_ra];
    end

endmodule

FILE: rtl/core/binary_trie_lpm_table_top.sv
// Sequence: an item that misses at the root goes straight to its result; else each trie
// level walked is a node memory read then a check, an insert then builds the missing
// nodes, and a delete prunes the nodes it leaves empty.
// Items: one item at a time in the sequencer; the next is taken once the result is loaded out.
// Reset: synchronous, active low; empties the tree and both counters, no memory sweep.
module binary_trie_lpm_table_top
    import btlpm_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
    parameter int NODE_ENTRIES  = NODE_ENTRIES_DEF
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [REQ_W-1:0]     i_req_type,
    input  logic [ADDR_BITS-1:0] i_prefix_bits,
    input  logic [LEN_W-1:0]     i_prefix_len,
    input  logic [DATA_W-1:0]    i_data_in,
    input  logic                 i_clear_hits,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic [DATA_W-1:0]    o_data_out,
    output logic [LEN_W-1:0]     o_match_len,
    output logic [DATA_W-1:0]    o_hits
);

    logic               r_hce;
    logic [LIMIT_W-1:0] r_limit;
    logic               cfg_wr;
    logic               item_valid;
    t_item              item;
    logic               pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_HCE) ? {31'd0, r_hce} : {23'd0, r_limit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hce   <= 1'b0;
            r_limit <= ROUTE_LIMIT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_HCE) begin
                r_hce <= pwdata[0];
            end else begin
                r_limit <= pwdata[LIMIT_W-1:0];
            end
        end
    end

    btlpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_prefix_bits (i_prefix_bits),
        .i_prefix_len  (i_prefix_len),
        .i_data_in     (i_data_in),
        .i_clear_hits  (i_clear_hits),
        .o_item_valid  (item_valid),
        .o_item        (item),
        .i_pop         (pop)
    );

    btlpm_back #(
        .ROUTE_ENTRIES (ROUTE_ENTRIES),
        .NODE_ENTRIES  (NODE_ENTRIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_pop         (pop),
        .i_hce         (r_hce),
        .i_limit       (r_limit),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_data_out    (o_data_out),
        .o_match_len   (o_match_len),
        .o_hits        (o_hits)
    );

endmodule

FILE: rtl/core/btlpm_checker.sv
module btlpm_checker
    import btlpm_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [STAT_W-1:0] o_status,
    input logic [DATA_W-1:0] o_data_out,
    input logic [LEN_W-1:0]  o_match_len,
    input logic [DATA_W-1:0] o_hits
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STAT_OK || o_status == STAT_MISS ||
                         o_status == STAT_FULL))
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STAT_OK) |->
            (o_data_out == '0 && o_match_len == '0 && o_hits == '0))
        else $error("failed request carries payload");

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_match_len <= LEN_W'(ADDR_BITS)))
        else $error("match length beyond address width");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_data_out)))
        else $error("stalled result changed");

endmodule

bind binary_trie_lpm_table_top btlpm_checker u_chk (.*);
